// ----- hdl/ccr_pkg.sv -----
// Package with the shared types, constants and helper functions of the collision response block.
`default_nettype none
package ccr_pkg;

    localparam int S_TDATA_W = 328;
    localparam int M_TDATA_W = 104;
    localparam int S_TUSER_W = 1;
    localparam int M_TUSER_W = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_SURF_REST = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OBST_REST = 1'd1;

    localparam logic KIND_PLANE = 1'b0;
    localparam logic KIND_OBST  = 1'b1;

    localparam logic [16:0] ONE_Q16 = 17'd65536;

    // Pipeline layout.
    localparam int ST_IN   = 0;
    localparam int ST_DIFF = 1;
    localparam int ST_MUL  = 2;
    localparam int ST_DEC  = 3;
    localparam int ST_SUM  = 4;
    localparam int ST_SQ0  = 5;
    localparam int SQ_STG  = 16;
    localparam int SQ_PER  = 2;
    localparam int ST_NUM  = ST_SQ0 + SQ_STG;
    localparam int ST_DV0  = ST_NUM + 1;
    localparam int DV_STG  = 9;
    localparam int DV_PER  = 2;
    localparam int DV_BITS = 17;
    localparam int ST_NRM  = ST_DV0 + DV_STG;
    localparam int ST_VP   = ST_NRM + 1;
    localparam int ST_VN   = ST_VP + 1;
    localparam int ST_IP   = ST_VN + 1;
    localparam int ST_MS   = ST_IP + 1;
    localparam int ST_MP   = ST_MS + 1;
    localparam int ST_OUT  = ST_MP + 1;
    localparam int NSTG    = ST_OUT + 1;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] probe_vx;
        logic signed [31:0] probe_vy;
        logic        [30:0] reach;
        logic signed [31:0] other_x;
        logic signed [31:0] other_y;
        logic signed [17:0] plane_nx;
        logic signed [17:0] plane_ny;
    } ccr_in_t;

    typedef struct packed {
        logic               hit;
        logic               resting;
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic signed [17:0] contact_nx;
        logic signed [17:0] contact_ny;
    } ccr_out_t;

    // Everything one item carries down the pipeline.
    typedef struct packed {
        ccr_in_t            din;
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic        [30:0] ax;
        logic        [30:0] ay;
        logic               far;
        logic signed [50:0] pd_x;
        logic signed [50:0] pd_y;
        logic signed [49:0] pp_x;
        logic signed [49:0] pp_y;
        logic        [61:0] sq_x;
        logic        [61:0] sq_y;
        logic        [61:0] r2;
        logic signed [63:0] od_x;
        logic signed [63:0] od_y;
        logic        [30:0] axs;
        logic        [30:0] ays;
        logic               hit;
        logic        [61:0] hx2;
        logic        [61:0] hy2;
        logic        [63:0] sq_s;
        logic        [63:0] sq_r;
        logic        [31:0] len;
        logic        [48:0] rem_x;
        logic        [48:0] rem_y;
        logic        [16:0] q_x;
        logic        [16:0] q_y;
        logic signed [17:0] nx;
        logic signed [17:0] ny;
        logic signed [49:0] pv_x;
        logic signed [49:0] pv_y;
        logic signed [34:0] vn;
        logic               resting;
        logic        [52:0] ip;
        logic signed [37:0] mm;
        logic signed [55:0] mp_x;
        logic signed [55:0] mp_y;
        ccr_out_t           res;
    } ccr_pipe_t;

    // Leading zero count of a 31-bit magnitude.
    function automatic logic [4:0] lzc31(input logic [30:0] m);
        logic [4:0] n;
        n = 5'd0;
        for (int i = 0; i < 31; i++) begin
            if (m[i]) begin
                n = 5'(30 - i);
            end
        end
        return n;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [41:0] x);
        logic signed [31:0] y;
        if (x > 42'sd2147483647) begin
            y = 32'sh7FFFFFFF;
        end
        else if (x < -42'sd2147483648) begin
            y = 32'sh80000000;
        end
        else begin
            y = x[31:0];
        end
        return y;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/ccr_core.sv -----
// Staged datapath of the collision test and velocity response, with per-stage flow control.
`default_nettype none
module ccr_core (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire ccr_pkg::ccr_in_t      in_word,
    input  wire logic [16:0]           e_surf,
    input  wire logic [16:0]           e_obst,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output ccr_pkg::ccr_out_t          out_word
);
    import ccr_pkg::*;

    ccr_pipe_t       stage_reg [NSTG];
    ccr_pipe_t       stage_next[NSTG];
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] free;

    // A stage takes new data when it is empty or its content moves on.
    always_comb
    begin
        free[NSTG-1] = !vld_reg[NSTG-1] || out_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            free[k] = !vld_reg[k] || free[k+1];
        end
    end

    // No word is taken while reset holds the pipeline empty.
    assign in_ready  = free[0] && rst_n;
    assign out_valid = vld_reg[NSTG-1];
    assign out_word  = stage_reg[NSTG-1].res;

    always_comb
    begin
        ccr_pipe_t          q;
        logic        [32:0] ax33;
        logic        [32:0] ay33;
        logic        [30:0] mx;
        logic        [4:0]  sh;
        logic signed [51:0] pl_dot;
        logic signed [50:0] pdot;
        logic        [62:0] s;
        logic signed [64:0] odot;
        logic               hit_p;
        logic               hit_o;
        logic        [63:0] ss;
        logic        [63:0] rr;
        logic        [63:0] bb;
        logic        [48:0] dvs;
        int                 it;
        int                 kk;
        logic        [16:0] qc_x;
        logic        [16:0] qc_y;
        logic signed [17:0] on_x;
        logic signed [17:0] on_y;
        logic signed [50:0] vsum;
        logic        [34:0] nv;
        logic        [17:0] e1;
        logic        [53:0] imp54;
        logic signed [56:0] t_x;
        logic signed [56:0] t_y;
        logic signed [40:0] rr_x;
        logic signed [40:0] rr_y;
        logic signed [41:0] rx;
        logic signed [41:0] ry;

        stage_next[ST_IN] = '0;
        stage_next[ST_IN].din = in_word;
        for (int k = 1; k < NSTG; k++) begin
            stage_next[k] = stage_reg[k-1];
        end

        // Offset and magnitudes.
        q = stage_reg[ST_DIFF-1];
        stage_next[ST_DIFF].dx = {q.din.pos_x[31], q.din.pos_x} - {q.din.other_x[31], q.din.other_x};
        stage_next[ST_DIFF].dy = {q.din.pos_y[31], q.din.pos_y} - {q.din.other_y[31], q.din.other_y};
        ax33 = stage_next[ST_DIFF].dx[32] ? 33'(-stage_next[ST_DIFF].dx)
                                          : 33'(stage_next[ST_DIFF].dx);
        ay33 = stage_next[ST_DIFF].dy[32] ? 33'(-stage_next[ST_DIFF].dy)
                                          : 33'(stage_next[ST_DIFF].dy);
        stage_next[ST_DIFF].far = ax33[32] | ax33[31] | ay33[32] | ay33[31];
        stage_next[ST_DIFF].ax  = ax33[30:0];
        stage_next[ST_DIFF].ay  = ay33[30:0];

        // Products for both detection tests, and normalization of the offset.
        q = stage_reg[ST_MUL-1];
        stage_next[ST_MUL].pd_x = q.dx * q.din.plane_nx;
        stage_next[ST_MUL].pd_y = q.dy * q.din.plane_ny;
        stage_next[ST_MUL].pp_x = q.din.probe_vx * q.din.plane_nx;
        stage_next[ST_MUL].pp_y = q.din.probe_vy * q.din.plane_ny;
        stage_next[ST_MUL].sq_x = q.ax * q.ax;
        stage_next[ST_MUL].sq_y = q.ay * q.ay;
        stage_next[ST_MUL].r2   = q.din.reach * q.din.reach;
        stage_next[ST_MUL].od_x = $signed(q.dx[31:0]) * q.din.probe_vx;
        stage_next[ST_MUL].od_y = $signed(q.dy[31:0]) * q.din.probe_vy;
        mx = (q.ax > q.ay) ? q.ax : q.ay;
        sh = lzc31(mx);
        stage_next[ST_MUL].axs = q.ax << sh;
        stage_next[ST_MUL].ays = q.ay << sh;

        // Hit decision.
        q = stage_reg[ST_DEC-1];
        pl_dot = q.pd_x + q.pd_y;
        pdot   = q.pp_x + q.pp_y;
        s      = q.sq_x + q.sq_y;
        odot   = q.od_x + q.od_y;
        hit_p  = (pl_dot < $signed({5'd0, q.din.reach, 16'd0})) && pdot[50];
        hit_o  = !q.far && (s != 63'd0) && (s < {1'b0, q.r2}) && odot[64];
        stage_next[ST_DEC].hit = (q.din.kind == KIND_OBST) ? hit_o : hit_p;
        stage_next[ST_DEC].hx2 = q.axs * q.axs;
        stage_next[ST_DEC].hy2 = q.ays * q.ays;

        q = stage_reg[ST_SUM-1];
        stage_next[ST_SUM].sq_s = q.hx2 + q.hy2;
        stage_next[ST_SUM].sq_r = 64'd0;

        // Square root, two result bits per stage.
        for (int j = 0; j < SQ_STG; j++) begin
            ss = stage_reg[ST_SQ0+j-1].sq_s;
            rr = stage_reg[ST_SQ0+j-1].sq_r;
            for (int t = 0; t < SQ_PER; t++) begin
                it = j * SQ_PER + t;
                bb = 64'd1 << (62 - 2 * it);
                if (ss >= rr + bb) begin
                    ss = ss - (rr + bb);
                    rr = (rr >> 1) + bb;
                end
                else begin
                    rr = rr >> 1;
                end
            end
            stage_next[ST_SQ0+j].sq_s = ss;
            stage_next[ST_SQ0+j].sq_r = rr;
        end

        // Dividends for the two normal components, rounded to nearest.
        q = stage_reg[ST_NUM-1];
        stage_next[ST_NUM].len   = q.sq_r[31:0];
        stage_next[ST_NUM].rem_x = {2'd0, q.axs, 16'd0} + {18'd0, q.sq_r[31:1]};
        stage_next[ST_NUM].rem_y = {2'd0, q.ays, 16'd0} + {18'd0, q.sq_r[31:1]};
        stage_next[ST_NUM].q_x   = 17'd0;
        stage_next[ST_NUM].q_y   = 17'd0;

        // Restoring division, two quotient bits per stage.
        for (int j = 0; j < DV_STG; j++) begin
            for (int t = 0; t < DV_PER; t++) begin
                it = j * DV_PER + t;
                if (it < DV_BITS) begin
                    kk  = DV_BITS - 1 - it;
                    dvs = 49'(stage_next[ST_DV0+j].len) << kk;
                    if (stage_next[ST_DV0+j].rem_x >= dvs) begin
                        stage_next[ST_DV0+j].rem_x = stage_next[ST_DV0+j].rem_x - dvs;
                        stage_next[ST_DV0+j].q_x[kk] = 1'b1;
                    end
                    if (stage_next[ST_DV0+j].rem_y >= dvs) begin
                        stage_next[ST_DV0+j].rem_y = stage_next[ST_DV0+j].rem_y - dvs;
                        stage_next[ST_DV0+j].q_y[kk] = 1'b1;
                    end
                end
            end
        end

        // Contact normal: zero on a miss, else the clamped obstacle normal or the surface normal as given.
        q = stage_reg[ST_NRM-1];
        qc_x = (q.q_x > ONE_Q16) ? ONE_Q16 : q.q_x;
        qc_y = (q.q_y > ONE_Q16) ? ONE_Q16 : q.q_y;
        on_x = q.dx[32] ? -$signed({1'b0, qc_x}) : $signed({1'b0, qc_x});
        on_y = q.dy[32] ? -$signed({1'b0, qc_y}) : $signed({1'b0, qc_y});
        if (!q.hit) begin
            stage_next[ST_NRM].nx = 18'sd0;
            stage_next[ST_NRM].ny = 18'sd0;
        end
        else if (q.din.kind == KIND_OBST) begin
            stage_next[ST_NRM].nx = on_x;
            stage_next[ST_NRM].ny = on_y;
        end
        else begin
            stage_next[ST_NRM].nx = q.din.plane_nx;
            stage_next[ST_NRM].ny = q.din.plane_ny;
        end

        q = stage_reg[ST_VP-1];
        stage_next[ST_VP].pv_x = q.din.vel_x * q.nx;
        stage_next[ST_VP].pv_y = q.din.vel_y * q.ny;

        // Normal speed, rounded to Q16.16.
        q = stage_reg[ST_VN-1];
        vsum = q.pv_x + q.pv_y + 51'sd32768;
        stage_next[ST_VN].vn      = vsum[50:16];
        stage_next[ST_VN].resting = q.hit && !vsum[50];

        // Impulse magnitude times (restitution + 1).
        q = stage_reg[ST_IP-1];
        nv = 35'(-q.vn);
        e1 = {1'b0, (q.din.kind == KIND_OBST) ? e_obst : e_surf} + {1'b0, ONE_Q16};
        stage_next[ST_IP].ip = nv * e1;

        q = stage_reg[ST_MS-1];
        imp54 = {1'b0, q.ip} + 54'd32768;
        if (q.resting) begin
            stage_next[ST_MS].mm = 38'(q.vn);
        end
        else begin
            stage_next[ST_MS].mm = $signed({1'b0, imp54[52:16]});
        end

        q = stage_reg[ST_MP-1];
        stage_next[ST_MP].mp_x = q.mm * q.nx;
        stage_next[ST_MP].mp_y = q.mm * q.ny;

        // Apply the response and saturate.
        q = stage_reg[ST_OUT-1];
        t_x  = q.mp_x + 57'sd32768;
        t_y  = q.mp_y + 57'sd32768;
        rr_x = t_x[56:16];
        rr_y = t_y[56:16];
        if (!q.hit) begin
            rx = 42'(q.din.vel_x);
            ry = 42'(q.din.vel_y);
        end
        else if (q.resting) begin
            rx = q.din.vel_x - rr_x;
            ry = q.din.vel_y - rr_y;
        end
        else begin
            rx = q.din.vel_x + rr_x;
            ry = q.din.vel_y + rr_y;
        end
        stage_next[ST_OUT].res.hit        = q.hit;
        stage_next[ST_OUT].res.resting    = q.resting;
        stage_next[ST_OUT].res.new_vel_x  = sat32(rx);
        stage_next[ST_OUT].res.new_vel_y  = sat32(ry);
        stage_next[ST_OUT].res.contact_nx = q.nx;
        stage_next[ST_OUT].res.contact_ny = q.ny;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= '0;
        end
        else begin
            if (free[0]) begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (free[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NSTG; k++) begin
            if (free[k]) begin
                stage_reg[k] <= stage_next[k];
            end
        end
    end

endmodule
`default_nettype wire

// ----- hdl/circle_collision_response.sv -----
// Top level of the circle collision response block: stream ports, restitution registers, datapath.
// Throughput: one word per cycle unless the output stalls; the square root (16 stages) and the two
// restoring dividers (9 stages) are fully pipelined, so nothing in the datapath iterates in place.
// Every stage has its own valid bit, so empty stages fill while the output is stalled.
// Reset (rst_n low, asynchronous) empties the pipeline and sets both restitutions to 1.0.
`default_nettype none
module circle_collision_response (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // pos_x, pos_y, vel_x, vel_y, probe_vx, probe_vy, reach, other_x, other_y,
    // plane_nx, plane_ny, then zero fill
    input  wire logic [ccr_pkg::S_TDATA_W-1:0]        s_tdata,
    // kind
    input  wire logic [ccr_pkg::S_TUSER_W-1:0]        s_tuser,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // new_vel_x, new_vel_y, contact_nx, contact_ny, then zero fill
    output logic [ccr_pkg::M_TDATA_W-1:0]             m_tdata,
    // hit, resting
    output logic [ccr_pkg::M_TUSER_W-1:0]             m_tuser,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [ccr_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [ccr_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import ccr_pkg::*;

    logic [16:0] surf_rest_reg;
    logic [16:0] surf_rest_next;
    logic [16:0] obst_rest_reg;
    logic [16:0] obst_rest_next;
    ccr_in_t     in_word;
    ccr_out_t    out_word;

    // The register port never stalls outside reset; the user must write only while the datapath
    // is idle, as it reads the restitution registers directly. The block does not enforce this.
    assign cfg_ready = rst_n;

    always_comb
    begin
        surf_rest_next = surf_rest_reg;
        obst_rest_next = obst_rest_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_SURF_REST: surf_rest_next = cfg_data;
                REG_OBST_REST: obst_rest_next = cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            surf_rest_reg <= ONE_Q16;
            obst_rest_reg <= ONE_Q16;
        end
        else begin
            surf_rest_reg <= surf_rest_next;
            obst_rest_reg <= obst_rest_next;
        end
    end

    // Unpack the input word, first field in the lowest bits.
    always_comb
    begin
        in_word.kind     = s_tuser[0];
        in_word.pos_x    = s_tdata[31:0];
        in_word.pos_y    = s_tdata[63:32];
        in_word.vel_x    = s_tdata[95:64];
        in_word.vel_y    = s_tdata[127:96];
        in_word.probe_vx = s_tdata[159:128];
        in_word.probe_vy = s_tdata[191:160];
        in_word.reach    = s_tdata[222:192];
        in_word.other_x  = s_tdata[254:223];
        in_word.other_y  = s_tdata[286:255];
        in_word.plane_nx = s_tdata[304:287];
        in_word.plane_ny = s_tdata[322:305];
    end

    ccr_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_word   (in_word),
        .e_surf    (surf_rest_reg),
        .e_obst    (obst_rest_reg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (out_word)
    );

    // Pack the result word.
    assign m_tdata = {4'd0, out_word.contact_ny, out_word.contact_nx,
                      out_word.new_vel_y, out_word.new_vel_x};
    assign m_tuser = {out_word.resting, out_word.hit};

endmodule
`default_nettype wire

// ----- hdl/ccr_checker.sv -----
// Port-level checker for the collision response block and its bind statement.
`default_nettype none
module ccr_checker (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 s_tvalid,
    input  wire logic                                 s_tready,
    input  wire logic [ccr_pkg::S_TDATA_W-1:0]        s_tdata,
    input  wire logic [ccr_pkg::S_TUSER_W-1:0]        s_tuser,
    input  wire logic                                 m_tvalid,
    input  wire logic                                 m_tready,
    input  wire logic [ccr_pkg::M_TDATA_W-1:0]        m_tdata,
    input  wire logic [ccr_pkg::M_TUSER_W-1:0]        m_tuser,
    input  wire logic                                 cfg_valid,
    input  wire logic                                 cfg_ready,
    input  wire logic [ccr_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [ccr_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import ccr_pkg::*;

    // Resting contact is a kind of hit.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[1] && !m_tuser[0]))
        else $error("resting word without hit");

    // A miss reports a zero contact normal.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[99:64] == 36'd0))
        else $error("miss with nonzero contact normal");

    // With no result waiting, the pipeline has room for a new word.
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty output");

    // A stalled result word holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result word changed");

endmodule

bind circle_collision_response ccr_checker u_ccr_checker (.*);
`default_nettype wire
